[rtl/core/quad_motor_mixer_with_arming_top_assert.svh]
// Assertion macros for the quad motor mixer checker.
`ifndef QUAD_MOTOR_MIXER_WITH_ARMING_TOP_ASSERT_SVH
`define QUAD_MOTOR_MIXER_WITH_ARMING_TOP_ASSERT_SVH

// Check on every clock edge outside reset.
`define QMM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define QMM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/qmm_pkg.sv]
// Shared types and constants of the quad motor mixer.
package qmm_pkg;

    localparam int STICK_W   = 11;
    localparam int CORR_W    = 16;
    localparam int POWER_W   = 16;
    localparam int CNT_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int SUM_W     = 19;

    typedef logic signed [STICK_W-1:0] stick_t;
    typedef logic signed [CORR_W-1:0]  corr_t;
    typedef logic signed [POWER_W-1:0] power_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [CNT_W-1:0]          cnt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_LIMIT   = 3'd0,
        REG_CORNER_LIMIT  = 3'd1,
        REG_DEADZONE      = 3'd2,
        REG_STOP_TICKS    = 3'd3,
        REG_POWER_FLOOR   = 3'd4,
        REG_POWER_CEILING = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [10:0] start_limit;
        logic [9:0]         corner_limit;
        logic [9:0]         deadzone;
        logic [14:0]        stop_ticks;
        logic signed [15:0] power_floor;
        logic signed [15:0] power_ceiling;
    } cfg_t;

    localparam logic signed [10:0] START_LIMIT_RST   = 11'sd200;
    localparam logic [9:0]         CORNER_LIMIT_RST  = 10'd800;
    localparam logic [9:0]         DEADZONE_RST      = 10'd30;
    localparam logic [14:0]        STOP_TICKS_RST    = 15'd1000;
    localparam logic signed [15:0] POWER_FLOOR_RST   = 16'sd0;
    localparam logic signed [15:0] POWER_CEILING_RST = 16'sd1000;

endpackage

[rtl/core/qmm_mix.sv]
// X-frame motor mix with full-width sums clipped to the power limits; all motors are zero while disarmed.
module qmm_mix
(
    input  qmm_pkg::cfg_t   cfg,
    input  logic            armed,
    input  logic            low_throttle,
    input  qmm_pkg::stick_t throttle,
    input  qmm_pkg::corr_t  pitch_corr,
    input  qmm_pkg::corr_t  roll_corr,
    input  qmm_pkg::corr_t  yaw_corr,
    output qmm_pkg::power_t motor_one,
    output qmm_pkg::power_t motor_two,
    output qmm_pkg::power_t motor_three,
    output qmm_pkg::power_t motor_four
);

    function automatic qmm_pkg::power_t clip
    (
        qmm_pkg::sum_t   v,
        qmm_pkg::power_t lo,
        qmm_pkg::power_t hi
    );
        qmm_pkg::sum_t f;
        qmm_pkg::sum_t c;
        qmm_pkg::sum_t w;
        f = qmm_pkg::sum_t'(lo);
        c = qmm_pkg::sum_t'(hi);
        w = v;
        if (w < f)
        begin
            w = f;
        end
        if (w > c)
        begin
            w = c;
        end
        return qmm_pkg::power_t'(w);
    endfunction

    qmm_pkg::sum_t t;
    qmm_pkg::sum_t p;
    qmm_pkg::sum_t r;
    qmm_pkg::sum_t y;
    qmm_pkg::sum_t s1;
    qmm_pkg::sum_t s2;
    qmm_pkg::sum_t s3;
    qmm_pkg::sum_t s4;

    // Corrections drop out at low throttle.
    assign t = qmm_pkg::sum_t'(throttle);
    assign p = low_throttle ? '0 : qmm_pkg::sum_t'(pitch_corr);
    assign r = low_throttle ? '0 : qmm_pkg::sum_t'(roll_corr);
    assign y = low_throttle ? '0 : qmm_pkg::sum_t'(yaw_corr);

    assign s1 = t + p - r - y;
    assign s2 = t + p + r + y;
    assign s3 = t - p + r - y;
    assign s4 = t - p - r + y;

    assign motor_one   = armed ? clip(s1, cfg.power_floor, cfg.power_ceiling) : '0;
    assign motor_two   = armed ? clip(s2, cfg.power_floor, cfg.power_ceiling) : '0;
    assign motor_three = armed ? clip(s3, cfg.power_floor, cfg.power_ceiling) : '0;
    assign motor_four  = armed ? clip(s4, cfg.power_floor, cfg.power_ceiling) : '0;

endmodule

[rtl/core/quad_motor_mixer_with_arming_top.sv]
// Top level of the quad motor mixer with stick arming.
// One control tick is one input beat and gives one output beat. The block
// takes a beat in every cycle while the output side is not stalled: a tick
// is held in an input register, goes through the arming logic and the X
// mix combinationally, and lands in the result register, from which its
// result beat is offered and held until the output side takes it. The
// arming state advances as a tick moves into the result register, so a
// stalled output holds the state too.
// Write configuration only while no tick is in flight; writes to indexes
// past the power ceiling are dropped.
module quad_motor_mixer_with_arming_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        arm_switch_on,
    input  logic signed [10:0] throttle_stick,
    input  logic signed [10:0] pitch_stick,
    input  logic signed [10:0] roll_stick,
    input  logic signed [10:0] rudder_stick,
    input  logic signed [15:0] pitch_correction,
    input  logic signed [15:0] roll_correction,
    input  logic signed [15:0] yaw_correction,

    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] motor_one,
    output logic signed [15:0] motor_two,
    output logic signed [15:0] motor_three,
    output logic signed [15:0] motor_four,
    output logic        is_armed,
    output logic        reset_integrals,
    output logic signed [10:0] pitch_target,
    output logic signed [10:0] roll_target,
    output logic signed [10:0] yaw_target
);

    function automatic qmm_pkg::stick_t dead_zone(qmm_pkg::stick_t x, logic [9:0] dz);
        logic signed [11:0] xe;
        logic signed [11:0] de;
        xe = {x[10], x};
        de = {2'b00, dz};
        return (xe >= -de && xe <= de) ? '0 : x;
    endfunction

    qmm_pkg::cfg_t   cfg_reg;

    logic            s_valid_reg;
    logic            sw_reg;
    qmm_pkg::stick_t thr_reg;
    qmm_pkg::stick_t pit_reg;
    qmm_pkg::stick_t rol_reg;
    qmm_pkg::stick_t rud_reg;
    qmm_pkg::corr_t  pc_reg;
    qmm_pkg::corr_t  rc_reg;
    qmm_pkg::corr_t  yc_reg;

    logic            armed_reg;
    logic            armed_next;
    logic            corner_seen_reg;
    logic            corner_seen_next;
    qmm_pkg::cnt_t   ticks_reg;
    qmm_pkg::cnt_t   ticks_next;

    logic            o_valid_reg;
    qmm_pkg::power_t m1_reg;
    qmm_pkg::power_t m2_reg;
    qmm_pkg::power_t m3_reg;
    qmm_pkg::power_t m4_reg;
    logic            armed_out_reg;
    logic            pulse_reg;
    qmm_pkg::stick_t pt_reg;
    qmm_pkg::stick_t rt_reg;
    qmm_pkg::stick_t yt_reg;

    logic               advance;
    logic               in_beat;
    logic               corner;
    logic               low_throttle;
    logic               armed_mid;
    logic               pulse;
    logic signed [11:0] rud_ext;
    logic signed [11:0] corner_ext;
    qmm_pkg::power_t    m1;
    qmm_pkg::power_t    m2;
    qmm_pkg::power_t    m3;
    qmm_pkg::power_t    m4;

    assign advance  = s_valid_reg && (!o_valid_reg || out_ready);
    assign in_ready = !s_valid_reg || advance;
    assign in_beat  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_limit   <= qmm_pkg::START_LIMIT_RST;
            cfg_reg.corner_limit  <= qmm_pkg::CORNER_LIMIT_RST;
            cfg_reg.deadzone      <= qmm_pkg::DEADZONE_RST;
            cfg_reg.stop_ticks    <= qmm_pkg::STOP_TICKS_RST;
            cfg_reg.power_floor   <= qmm_pkg::POWER_FLOOR_RST;
            cfg_reg.power_ceiling <= qmm_pkg::POWER_CEILING_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                qmm_pkg::REG_START_LIMIT:   cfg_reg.start_limit   <= cfg_data[10:0];
                qmm_pkg::REG_CORNER_LIMIT:  cfg_reg.corner_limit  <= cfg_data[9:0];
                qmm_pkg::REG_DEADZONE:      cfg_reg.deadzone      <= cfg_data[9:0];
                qmm_pkg::REG_STOP_TICKS:    cfg_reg.stop_ticks    <= cfg_data[14:0];
                qmm_pkg::REG_POWER_FLOOR:   cfg_reg.power_floor   <= cfg_data;
                qmm_pkg::REG_POWER_CEILING: cfg_reg.power_ceiling <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign rud_ext      = {rud_reg[10], rud_reg};
    assign corner_ext   = {2'b00, cfg_reg.corner_limit};
    assign corner       = (thr_reg < cfg_reg.start_limit) && (rud_ext > corner_ext);
    assign low_throttle = thr_reg <= cfg_reg.start_limit;

    always_comb
    begin
        corner_seen_next = corner_seen_reg;
        armed_mid        = armed_reg;
        pulse            = 1'b0;
        if (sw_reg)
        begin
            if (corner != corner_seen_reg)
            begin
                corner_seen_next = corner;
                if (corner && !armed_reg)
                begin
                    pulse     = 1'b1;
                    armed_mid = 1'b1;
                end
            end
        end
        else
        begin
            armed_mid = 1'b0;
        end

        armed_next = armed_mid;
        ticks_next = ticks_reg;
        if (armed_mid)
        begin
            if (low_throttle)
            begin
                if (ticks_reg >= {1'b0, cfg_reg.stop_ticks})
                begin
                    armed_next = 1'b0;
                    ticks_next = '0;
                end
                else
                begin
                    ticks_next = ticks_reg + 16'd1;
                end
            end
            else
            begin
                ticks_next = '0;
            end
        end
    end

    qmm_mix u_mix
    (
        .cfg          (cfg_reg),
        .armed        (armed_mid),
        .low_throttle (low_throttle),
        .throttle     (thr_reg),
        .pitch_corr   (pc_reg),
        .roll_corr    (rc_reg),
        .yaw_corr     (yc_reg),
        .motor_one    (m1),
        .motor_two    (m2),
        .motor_three  (m3),
        .motor_four   (m4)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg     <= 1'b0;
            o_valid_reg     <= 1'b0;
            armed_reg       <= 1'b0;
            corner_seen_reg <= 1'b0;
            ticks_reg       <= '0;
        end
        else
        begin
            if (in_beat)
            begin
                s_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                o_valid_reg     <= 1'b1;
                armed_reg       <= armed_next;
                corner_seen_reg <= corner_seen_next;
                ticks_reg       <= ticks_next;
            end
            else if (out_ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            sw_reg  <= arm_switch_on;
            thr_reg <= throttle_stick;
            pit_reg <= pitch_stick;
            rol_reg <= roll_stick;
            rud_reg <= rudder_stick;
            pc_reg  <= pitch_correction;
            rc_reg  <= roll_correction;
            yc_reg  <= yaw_correction;
        end
        if (advance)
        begin
            m1_reg        <= m1;
            m2_reg        <= m2;
            m3_reg        <= m3;
            m4_reg        <= m4;
            armed_out_reg <= armed_next;
            pulse_reg     <= pulse;
            pt_reg        <= dead_zone(pit_reg, cfg_reg.deadzone);
            rt_reg        <= dead_zone(rol_reg, cfg_reg.deadzone);
            yt_reg        <= dead_zone(rud_reg, cfg_reg.deadzone);
        end
    end

    assign out_valid       = o_valid_reg;
    assign motor_one       = m1_reg;
    assign motor_two       = m2_reg;
    assign motor_three     = m3_reg;
    assign motor_four      = m4_reg;
    assign is_armed        = armed_out_reg;
    assign reset_integrals = pulse_reg;
    assign pitch_target    = pt_reg;
    assign roll_target     = rt_reg;
    assign yaw_target      = yt_reg;

endmodule

[rtl/core/qmm_check.sv]
// Port checker for the quad motor mixer, bound to the top level.
`include "quad_motor_mixer_with_arming_top_assert.svh"

module qmm_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic signed [15:0] motor_one,
    input logic signed [15:0] motor_two,
    input logic signed [15:0] motor_three,
    input logic signed [15:0] motor_four,
    input logic        is_armed,
    input logic        reset_integrals
);

    logic [64:0] out_word;
    logic        pulse_beat;

    assign out_word   = {motor_one, motor_two, motor_three, motor_four, is_armed};
    assign pulse_beat = out_valid && reset_integrals;

    `QMM_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |-> !out_valid, "result beat during reset")

    `QMM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word), "stalled result beat changed")

    `QMM_ASSERT(a_pulse_single, pulse_beat && out_ready |=> !pulse_beat, "integral reset on back to back ticks")

endmodule

bind quad_motor_mixer_with_arming_top qmm_check u_check
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .motor_one       (motor_one),
    .motor_two       (motor_two),
    .motor_three     (motor_three),
    .motor_four      (motor_four),
    .is_armed        (is_armed),
    .reset_integrals (reset_integrals)
);

[test/tb_quad_motor_mixer_with_arming_top.sv]
// Testbench for the quad motor mixer: random arming flights checked beat by beat.
`timescale 1ns / 100ps

module tb_quad_motor_mixer_with_arming_top;

    localparam int CYCLE_LIMIT = 150000;
    localparam int PHASE_ITEMS = 104;
    localparam int NUM_PHASES  = 8;

    typedef struct packed {
        logic            sw;
        qmm_pkg::stick_t thr;
        qmm_pkg::stick_t pit;
        qmm_pkg::stick_t rol;
        qmm_pkg::stick_t rud;
        qmm_pkg::corr_t  pc;
        qmm_pkg::corr_t  rc;
        qmm_pkg::corr_t  yc;
    } stick_frame_t;

    typedef struct packed {
        qmm_pkg::power_t m1;
        qmm_pkg::power_t m2;
        qmm_pkg::power_t m3;
        qmm_pkg::power_t m4;
        logic            armed;
        logic            pulse;
        qmm_pkg::stick_t pt;
        qmm_pkg::stick_t rt;
        qmm_pkg::stick_t yt;
    } mix_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        arm_switch_on = 1'b0;
    logic signed [10:0] throttle_stick = '0;
    logic signed [10:0] pitch_stick = '0;
    logic signed [10:0] roll_stick = '0;
    logic signed [10:0] rudder_stick = '0;
    logic signed [15:0] pitch_correction = '0;
    logic signed [15:0] roll_correction = '0;
    logic signed [15:0] yaw_correction = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [15:0] motor_one;
    logic signed [15:0] motor_two;
    logic signed [15:0] motor_three;
    logic signed [15:0] motor_four;
    logic        is_armed;
    logic        reset_integrals;
    logic signed [10:0] pitch_target;
    logic signed [10:0] roll_target;
    logic signed [10:0] yaw_target;

    qmm_pkg::cfg_t mix_cfg = '{qmm_pkg::START_LIMIT_RST, qmm_pkg::CORNER_LIMIT_RST,
                               qmm_pkg::DEADZONE_RST, qmm_pkg::STOP_TICKS_RST,
                               qmm_pkg::POWER_FLOOR_RST, qmm_pkg::POWER_CEILING_RST};
    logic model_armed = 1'b0;
    logic model_corner = 1'b0;
    qmm_pkg::cnt_t model_low_ticks = '0;

    stick_frame_t pending_frames[$];
    mix_out_t     predicted_mixes[$];
    stick_frame_t cur_frame;
    mix_out_t     want;

    int frames_pushed = 0;
    int results_seen = 0;
    int fail_count = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int recv_hold = 0;
    int unsigned cycle_count = 0;
    bit calm = 1'b0;
    bit long_hold_req = 1'b0;
    bit long_hold_done = 1'b0;

    quad_motor_mixer_with_arming_top dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .arm_switch_on    (arm_switch_on),
        .throttle_stick   (throttle_stick),
        .pitch_stick      (pitch_stick),
        .roll_stick       (roll_stick),
        .rudder_stick     (rudder_stick),
        .pitch_correction (pitch_correction),
        .roll_correction  (roll_correction),
        .yaw_correction   (yaw_correction),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .motor_one        (motor_one),
        .motor_two        (motor_two),
        .motor_three      (motor_three),
        .motor_four       (motor_four),
        .is_armed         (is_armed),
        .reset_integrals  (reset_integrals),
        .pitch_target     (pitch_target),
        .roll_target      (roll_target),
        .yaw_target       (yaw_target)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int pick(int lo, int hi);
        if (hi <= lo)
            return lo;
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic qmm_pkg::power_t clip_power(int v);
        int lo;
        int hi;
        lo = $signed(mix_cfg.power_floor);
        hi = $signed(mix_cfg.power_ceiling);
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return qmm_pkg::power_t'(v);
    endfunction

    function automatic qmm_pkg::stick_t dead_band(qmm_pkg::stick_t x);
        int dz;
        int v;
        dz = mix_cfg.deadzone;
        v = x;
        return (v >= -dz && v <= dz) ? qmm_pkg::stick_t'(0) : x;
    endfunction

    function automatic mix_out_t mix_tick(stick_frame_t f);
        int thr;
        int pc;
        int rc;
        int yc;
        int lim_start;
        int lim_corner;
        logic corner;
        mix_out_t r;
        thr = f.thr;
        pc = f.pc;
        rc = f.rc;
        yc = f.yc;
        lim_start = $signed(mix_cfg.start_limit);
        lim_corner = mix_cfg.corner_limit;
        corner = (thr < lim_start) && (int'(f.rud) > lim_corner);
        r = '0;
        if (f.sw)
        begin
            if (corner != model_corner)
            begin
                model_corner = corner;
                if (corner && !model_armed)
                begin
                    r.pulse = 1'b1;
                    model_armed = 1'b1;
                end
            end
        end
        else
        begin
            model_armed = 1'b0;
        end
        if (model_armed)
        begin
            if (thr <= lim_start)
            begin
                pc = 0;
                rc = 0;
                yc = 0;
            end
            r.m1 = clip_power(thr + pc - rc - yc);
            r.m2 = clip_power(thr + pc + rc + yc);
            r.m3 = clip_power(thr - pc + rc - yc);
            r.m4 = clip_power(thr - pc - rc + yc);
            if (thr <= lim_start)
            begin
                if (model_low_ticks >= mix_cfg.stop_ticks)
                begin
                    model_armed = 1'b0;
                    model_low_ticks = '0;
                end
                else
                begin
                    model_low_ticks = model_low_ticks + 1'b1;
                end
            end
            else
            begin
                model_low_ticks = '0;
            end
        end
        r.armed = model_armed;
        r.pt = dead_band(f.pit);
        r.rt = dead_band(f.rol);
        r.yt = dead_band(f.rud);
        return r;
    endfunction

    function automatic int rand_stick();
        int dz;
        dz = mix_cfg.deadzone;
        case ($urandom_range(5))
            0: return dz;
            1: return -dz;
            2: return dz + 1;
            3: return -dz - 1;
            default: return int'(qmm_pkg::stick_t'($urandom));
        endcase
    endfunction

    function automatic int rand_corr();
        if ($urandom_range(2) == 0)
            return int'(qmm_pkg::corr_t'($urandom));
        return int'($urandom_range(400)) - 200;
    endfunction

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    task automatic push_frame(bit sw, int thr, int pit, int rol, int rud,
                              int pc, int rc, int yc);
        stick_frame_t f;
        f.sw = sw;
        f.thr = qmm_pkg::stick_t'(thr);
        f.pit = qmm_pkg::stick_t'(pit);
        f.rol = qmm_pkg::stick_t'(rol);
        f.rud = qmm_pkg::stick_t'(rud);
        f.pc = qmm_pkg::corr_t'(pc);
        f.rc = qmm_pkg::corr_t'(rc);
        f.yc = qmm_pkg::corr_t'(yc);
        pending_frames.push_back(f);
        frames_pushed++;
    endtask

    task automatic push_noise();
        push_frame($urandom_range(1), rand_stick(), rand_stick(), rand_stick(), rand_stick(),
                   rand_corr(), rand_corr(), rand_corr());
    endtask

    task automatic push_flight();
        int lim_start;
        int lim_corner;
        int stop;
        int n;
        int k;
        int run;
        lim_start = $signed(mix_cfg.start_limit);
        lim_corner = mix_cfg.corner_limit;
        stop = mix_cfg.stop_ticks;
        n = pick(1, 3);
        for (k = 0; k < n; k++)
            push_frame(1, pick(lim_start, 1023), rand_stick(), rand_stick(), rand_stick(),
                       rand_corr(), rand_corr(), rand_corr());
        push_frame(1, pick(-1024, lim_start - 1), rand_stick(), rand_stick(),
                   pick(lim_corner + 1, 1023), rand_corr(), rand_corr(), rand_corr());
        n = pick(4, 24);
        for (k = 0; k < n; k++)
        begin
            case ($urandom_range(9))
                0:
                begin
                    run = pick(1, (stop < 37) ? stop + 3 : 40);
                    repeat (run)
                        push_frame(1, pick(-1024, lim_start), rand_stick(), rand_stick(),
                                   pick(-1024, lim_corner), rand_corr(), rand_corr(),
                                   rand_corr());
                end
                1: push_frame(0, rand_stick(), rand_stick(), rand_stick(), rand_stick(),
                              rand_corr(), rand_corr(), rand_corr());
                default: push_frame(1, pick(lim_start + 1, 1023), rand_stick(), rand_stick(),
                                    rand_stick(), rand_corr(), rand_corr(), rand_corr());
            endcase
        end
    endtask

    task automatic fill_phase(int count);
        int base;
        base = frames_pushed;
        while (frames_pushed - base < count)
        begin
            if ($urandom_range(4) == 0)
                push_noise();
            else
                push_flight();
        end
    endtask

    task automatic wait_all_results();
        while (results_seen < frames_pushed)
            @(posedge clk);
    endtask

    task automatic set_reg(qmm_pkg::cfg_idx_t idx, int val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val[15:0];
        case (idx)
            qmm_pkg::REG_START_LIMIT:   mix_cfg.start_limit = val[10:0];
            qmm_pkg::REG_CORNER_LIMIT:  mix_cfg.corner_limit = val[9:0];
            qmm_pkg::REG_DEADZONE:      mix_cfg.deadzone = val[9:0];
            qmm_pkg::REG_STOP_TICKS:    mix_cfg.stop_ticks = val[14:0];
            qmm_pkg::REG_POWER_FLOOR:   mix_cfg.power_floor = val[15:0];
            qmm_pkg::REG_POWER_CEILING: mix_cfg.power_ceiling = val[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(int start_lim, int corner_lim, int dz, int stop,
                                 int floor_lim, int ceil_lim);
        set_reg(qmm_pkg::REG_START_LIMIT, start_lim);
        set_reg(qmm_pkg::REG_CORNER_LIMIT, corner_lim);
        set_reg(qmm_pkg::REG_DEADZONE, dz);
        set_reg(qmm_pkg::REG_STOP_TICKS, stop);
        set_reg(qmm_pkg::REG_POWER_FLOOR, floor_lim);
        set_reg(qmm_pkg::REG_POWER_CEILING, ceil_lim);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Driver: advance to the next frame once the current beat is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predicted_mixes.push_back(mix_tick(cur_frame));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(5) == 0)
                begin
                    send_gap = $urandom_range(6);
                    in_valid <= 1'b0;
                end
                else if (pending_frames.size() != 0)
                begin
                    cur_frame = pending_frames.pop_front();
                    arm_switch_on <= cur_frame.sw;
                    throttle_stick <= cur_frame.thr;
                    pitch_stick <= cur_frame.pit;
                    roll_stick <= cur_frame.rol;
                    rudder_stick <= cur_frame.rud;
                    pitch_correction <= cur_frame.pc;
                    roll_correction <= cur_frame.rc;
                    yaw_correction <= cur_frame.yc;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (predicted_mixes.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual motor_one %0d",
                             $time, motor_one);
                    fail_count++;
                end
                else
                begin
                    want = predicted_mixes.pop_front();
                    check_field("motor_one", want.m1, motor_one);
                    check_field("motor_two", want.m2, motor_two);
                    check_field("motor_three", want.m3, motor_three);
                    check_field("motor_four", want.m4, motor_four);
                    check_field("is_armed", want.armed, is_armed);
                    check_field("reset_integrals", want.pulse, reset_integrals);
                    check_field("pitch_target", want.pt, pitch_target);
                    check_field("roll_target", want.rt, roll_target);
                    check_field("yaw_target", want.yt, yaw_target);
                end
            end
            if (long_hold_req && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                recv_hold = 80;
            end
            if (recv_hold > 0)
            begin
                recv_hold = recv_hold - 1;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap = recv_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(5) == 0)
            begin
                recv_gap = $urandom_range(6);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int phase;
        int floor_lim;
        int ceil_lim;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        push_frame(0, 1023, 1023, 1023, 1023, 32767, 32767, 32767);
        push_frame(0, -1024, -1024, -1024, -1024, -32768, -32768, -32768);
        push_frame(1, 0, 30, -30, 0, 100, 100, 100);
        push_frame(1, -1024, 31, -31, 1023, 32767, -32768, 32767);
        push_frame(1, 199, 0, 0, 801, 0, 0, 0);
        push_frame(1, 1023, 0, 0, 0, 32767, 32767, 32767);
        push_frame(1, 1023, 0, 0, 0, -32768, -32768, -32768);
        push_frame(1, 500, 1023, -1024, -1024, 32767, -32768, -32768);
        push_frame(1, 201, 0, 0, 0, 300, -200, 100);
        push_frame(1, 200, 0, 0, 800, 5000, 5000, 5000);
        push_frame(0, 500, 0, 0, 0, 100, 100, 100);
        push_frame(1, 100, 0, 0, 900, 100, 100, 100);
        push_frame(0, 100, 0, 0, 900, 100, 100, 100);
        push_frame(1, 100, 0, 0, 900, 100, 100, 100);
        push_frame(1, 600, 0, 0, 0, 100, 100, 100);
        push_frame(1, 150, 0, 0, 1000, 100, 100, 100);
        push_frame(1, 700, -31, 31, -1000, 1000, -1000, 500);
        wait_all_results();

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: apply_setting(200, 800, 30, 5, 0, 1000);
                1: apply_setting(1023, 0, 0, 0, -32768, 32767);
                2: apply_setting(-1024, 1023, 1023, 32767, 32767, -32768);
                default:
                begin
                    if ($urandom_range(1) == 0)
                    begin
                        floor_lim = pick(-3000, 500);
                        ceil_lim = pick(floor_lim, 4000);
                    end
                    else
                    begin
                        floor_lim = pick(-32768, 32767);
                        ceil_lim = pick(-32768, 32767);
                    end
                    apply_setting(pick(-300, 300), pick(0, 900), pick(0, 100), pick(0, 15),
                                  floor_lim, ceil_lim);
                end
            endcase
            if (phase == NUM_PHASES - 1)
                calm = 1'b1;
            fill_phase(PHASE_ITEMS);
            if (phase == 3)
                long_hold_req = 1'b1;
            wait_all_results();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && predicted_mixes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
